// File: rtl/brfc_pkg.sv
package brfc_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 4096;
  localparam int unsigned HEADER_BYTES    = 8;
  localparam int unsigned MIN_BLOCK_BYTES = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_MASK_ADD = 32'hA282EAD8;

  // Record type codes hashed ahead of the body.
  localparam logic [7:0] CODE_FULL   = 8'd1;
  localparam logic [7:0] CODE_FIRST  = 8'd2;
  localparam logic [7:0] CODE_MIDDLE = 8'd3;
  localparam logic [7:0] CODE_LAST   = 8'd4;

  typedef enum logic [1:0] {
    FRAG_FULL   = 2'd0,
    FRAG_FIRST  = 2'd1,
    FRAG_MIDDLE = 2'd2,
    FRAG_LAST   = 2'd3
  } frag_type_t;

  typedef struct packed {
    logic        is_header;
    logic [31:0] block_index;
    logic [11:0] byte_offset;
    logic [7:0]  body_byte;
    logic [31:0] masked_crc;
    logic [11:0] body_len;
    frag_type_t  fragment_type;
    logic [11:0] pad_bytes;
    logic        record_done;
  } result_t;

  // One byte of CRC32C, reflected, with pre/post inversion.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  function automatic logic [31:0] crc_mask(input logic [31:0] crc);
    return {crc[14:0], crc[31:15]} + CRC_MASK_ADD;
  endfunction

  localparam logic [31:0] SEED_FULL   = crc32c_byte(32'd0, CODE_FULL);
  localparam logic [31:0] SEED_FIRST  = crc32c_byte(32'd0, CODE_FIRST);
  localparam logic [31:0] SEED_MIDDLE = crc32c_byte(32'd0, CODE_MIDDLE);
  localparam logic [31:0] SEED_LAST   = crc32c_byte(32'd0, CODE_LAST);

endpackage

// File: rtl/brfc_out_queue.sv
module brfc_out_queue
  import brfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,     // only together with push0
  input  result_t data0,
  input  result_t data1,
  output logic    room_for_two,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     head;
  logic [QUEUE_AW-1:0]     tail;
  logic [QUEUE_AW:0]       count;
  logic [QUEUE_AW:0]       count_next;
  logic [QUEUE_AW-1:0]     tail_plus1;
  logic                    pop;
  logic [1:0]              n_push;

  assign pop          = out_valid & out_ready;
  assign n_push       = {1'b0, push0} + {1'b0, push1};
  assign tail_plus1   = tail + QUEUE_AW'(1);
  assign room_for_two = count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);
  assign out_valid    = count != '0;
  assign out_data     = entries[head];

  always_comb begin
    count_next = count + (QUEUE_AW + 1)'(n_push) - (QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + QUEUE_AW'(1);
      end
      tail <= tail + QUEUE_AW'(n_push);
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[tail] <= data0;
    end
    if (push1) begin
      entries[tail_plus1] <= data1;
    end
  end

endmodule

// File: rtl/block_record_fragmenter_crc32c_top.sv
// Record fragmenter with masked CRC32C fragment headers.
//
// s_*: one payload byte per transaction in s_tdata; s_tuser high when a byte
// is present, s_tlast high on the last byte of a record. s_tuser low with
// s_tlast high at record start yields an empty full fragment; otherwise an
// item without a byte is dropped.
// m_*: body byte results (m_tuser low) and fragment header results
// (m_tuser high); m_tlast marks the header that closes a record.
// cfg_*: block size in bytes, saturated to 16..4096, used from the next item.
//
// Each input transaction is processed in the cycle it is accepted and its
// one or two results are registered into a 4-entry output queue. Input is
// taken whenever the queue has two free slots: one byte per cycle as long
// as the sink drains; a fragment close adds a header result, so the output
// side sets the sustained rate. A sink stall fills the queue and then holds
// s_tready low; nothing is lost.
// Reset empties the queue, restores a 4096-byte block and starts a record.
module block_record_fragmenter_crc32c_top
  import brfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] payload_byte
  input  logic          s_tuser,   // byte_present
  input  logic          s_tlast,   // record_end
  output logic          m_tvalid,
  input  logic          m_tready,
  // [31:0] block_index, [43:32] byte_offset, [51:44] body_byte,
  // [83:52] masked_crc, [95:84] body_len, [97:96] fragment_type,
  // [109:98] pad_bytes, [111:110] zero
  output logic [111:0]  m_tdata,
  output logic          m_tuser,   // is_header
  output logic          m_tlast,   // record_done
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [12:0]   cfg_data   // block_bytes
);

  localparam logic [12:0] MIN_BLK = 13'(MIN_BLOCK_BYTES);
  localparam logic [12:0] MAX_BLK = 13'(MAX_BLOCK_BYTES);
  localparam logic [12:0] HDR     = 13'(HEADER_BYTES);
  localparam logic [11:0] AVAIL_RESET = 12'(MAX_BLOCK_BYTES - HEADER_BYTES);

  logic [11:0] avail;
  logic [31:0] crc_if_final;
  logic [31:0] crc_if_not_final;
  logic [11:0] fill_count;
  logic [31:0] fragment_index;
  logic        at_record_start;
  logic        first_fragment;

  logic        accept;
  logic        room_for_two;
  logic        push0;
  logic        push1;
  result_t     res0;
  result_t     res1;
  result_t     out_res;

  logic [31:0] crc_f_upd;
  logic [31:0] crc_nf_upd;
  logic [11:0] fill_inc;
  logic        closes;
  logic        empty_record;
  logic [12:0] blk_sat;

  assign cfg_ready = 1'b1;
  assign s_tready  = room_for_two;
  assign accept    = s_tvalid & s_tready;

  always_comb begin
    blk_sat = cfg_data;
    if (cfg_data < MIN_BLK) begin
      blk_sat = MIN_BLK;
    end else if (cfg_data > MAX_BLK) begin
      blk_sat = MAX_BLK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avail <= AVAIL_RESET;
    end else if (cfg_valid & cfg_ready) begin
      avail <= 12'(blk_sat - HDR);
    end
  end

  assign crc_f_upd    = crc32c_byte(crc_if_final, s_tdata);
  assign crc_nf_upd   = crc32c_byte(crc_if_not_final, s_tdata);
  assign fill_inc     = fill_count + 12'd1;
  assign closes       = s_tlast | (fill_inc >= avail);
  assign empty_record = ~s_tuser & at_record_start & s_tlast;

  always_comb begin
    res0 = '0;
    res1 = '0;
    if (!s_tuser) begin
      res0.is_header   = 1'b1;
      res0.masked_crc  = crc_mask(crc_if_final);
      res0.fragment_type = FRAG_FULL;
      res0.pad_bytes   = avail;
      res0.record_done = 1'b1;
    end else begin
      res0.block_index = fragment_index;
      res0.byte_offset = 12'(HEADER_BYTES) + fill_count;
      res0.body_byte   = s_tdata;
    end

    res1.is_header       = 1'b1;
    res1.block_index     = fragment_index;
    res1.body_len        = fill_inc;
    res1.record_done     = s_tlast;
    if (s_tlast) begin
      res1.fragment_type = first_fragment ? FRAG_FULL : FRAG_LAST;
      res1.masked_crc    = crc_mask(crc_f_upd);
      res1.pad_bytes     = (avail > fill_inc) ? (avail - fill_inc) : 12'd0;
    end else begin
      res1.fragment_type = first_fragment ? FRAG_FIRST : FRAG_MIDDLE;
      res1.masked_crc    = crc_mask(crc_nf_upd);
      res1.pad_bytes     = 12'd0;
    end
  end

  assign push0 = accept & (s_tuser | empty_record);
  assign push1 = accept & s_tuser & closes;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_if_final     <= SEED_FULL;
      crc_if_not_final <= SEED_FIRST;
      fill_count       <= '0;
      fragment_index   <= '0;
      at_record_start  <= 1'b1;
      first_fragment   <= 1'b1;
    end else if (accept & s_tuser) begin
      if (!closes) begin
        crc_if_final     <= crc_f_upd;
        crc_if_not_final <= crc_nf_upd;
        fill_count       <= fill_inc;
        at_record_start  <= 1'b0;
      end else if (s_tlast) begin
        crc_if_final     <= SEED_FULL;
        crc_if_not_final <= SEED_FIRST;
        fill_count       <= '0;
        fragment_index   <= '0;
        at_record_start  <= 1'b1;
        first_fragment   <= 1'b1;
      end else begin
        // body full, record continues in the next block
        crc_if_final     <= SEED_LAST;
        crc_if_not_final <= SEED_MIDDLE;
        fill_count       <= '0;
        fragment_index   <= fragment_index + 32'd1;
        at_record_start  <= 1'b0;
        first_fragment   <= 1'b0;
      end
    end
  end

  brfc_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push0        (push0),
    .push1        (push1),
    .data0        (res0),
    .data1        (res1),
    .room_for_two (room_for_two),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (out_res)
  );

  assign m_tuser = out_res.is_header;
  assign m_tlast = out_res.record_done;
  assign m_tdata = {2'b00, out_res.pad_bytes, out_res.fragment_type,
                    out_res.body_len, out_res.masked_crc, out_res.body_byte,
                    out_res.byte_offset, out_res.block_index};

endmodule
